FILE: hdl/egdiv_pkg.sv
// Shared widths and the stage record passed along the divider cell chain.
package egdiv_pkg;

	localparam int DATA_WIDTH = 31;
	localparam int NUM_CELLS  = DATA_WIDTH;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Everything one cell hands to the next.
	typedef struct packed {
		logic  vld;
		logic  dz;
		word_t rem;
		word_t num;
		word_t quo;
		word_t dvs;
	} stage_t;

endpackage

FILE: hdl/egdiv_cell.sv
// One halving step of the divider: trial subtract, retire one quotient bit.
module egdiv_cell
	import egdiv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  stage_t cur,
	output stage_t nxt
);

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH+1:0] diff;
	logic                  fits;
	word_t                 rem_n;

	logic  vld_q;
	logic  dz_q;
	word_t rem_q;
	word_t num_q;
	word_t quo_q;
	word_t dvs_q;

	// Bring down the next dividend bit, then see if the divisor fits.
	assign trial = {cur.rem, cur.num[DATA_WIDTH-1]};
	assign diff  = {1'b0, trial} - {2'b00, cur.dvs};
	assign fits  = ~diff[DATA_WIDTH+1];
	assign rem_n = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= cur.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_q  <= cur.dz;
			rem_q <= rem_n;
			num_q <= {cur.num[DATA_WIDTH-2:0], 1'b0};
			quo_q <= {cur.quo[DATA_WIDTH-2:0], fits};
			dvs_q <= cur.dvs;
		end
	end

	assign nxt = '{vld: vld_q, dz: dz_q, rem: rem_q, num: num_q, quo: quo_q, dvs: dvs_q};

endmodule

FILE: hdl/egyptian_divider_unit.sv
// Top level: unsigned divider built as a chain of shift-subtract cells.
//
//   channel  | valid         | ready         | payload
//   ---------+---------------+---------------+---------------------------------
//   item     | item_valid    | item_ready    | dividend, divisor_value
//   result   | result_valid  | result_ready  | quotient, divide_by_zero
//
// The chain holds one cell per quotient bit, each cell registering
// one trial subtract of the divisor. A new transaction enters every cycle
// while no result waits untaken. Reset clears only the valid bit of each cell.
// When a result waits untaken, the whole chain holds and item_ready drops.
// A zero divisor gives quotient 0 with divide_by_zero set.
module egyptian_divider_unit
	import egdiv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  word_t dividend,
	input  word_t divisor_value,
	output logic  result_valid,
	input  logic  result_ready,
	output word_t quotient,
	output logic  divide_by_zero
);

	stage_t st [0:NUM_CELLS];
	logic   adv;

	assign adv = ~st[NUM_CELLS].vld | result_ready;

	assign st[0] = '{
		vld: item_valid,
		dz:  (divisor_value == '0),
		rem: '0,
		num: dividend,
		quo: '0,
		dvs: divisor_value
	};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		egdiv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cur    (st[i]),
			.nxt    (st[i+1])
		);
	end

	assign item_ready     = adv;
	assign result_valid   = st[NUM_CELLS].vld;
	assign divide_by_zero = st[NUM_CELLS].dz;
	assign quotient       = st[NUM_CELLS].dz ? '0 : st[NUM_CELLS].quo;

endmodule

FILE: hdl/egdiv_checker.sv
// Port-level checks for the divider, bound to the top level.
module egdiv_checker
	import egdiv_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  item_ready,
	input logic  result_valid,
	input logic  result_ready,
	input word_t quotient,
	input logic  divide_by_zero
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(quotient) && $stable(divide_by_zero))
		else $error("result payload changed while stalled");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && divide_by_zero |-> quotient == '0)
		else $error("nonzero quotient on divide by zero");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("chain stalled with empty output");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item taken while output stalled");

endmodule

bind egyptian_divider_unit egdiv_checker u_egdiv_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the pipelined Egyptian divider.
`timescale 1ns / 1ps

module testbench;
	import egdiv_pkg::*;

	localparam int      CLK_PERIOD  = 12;
	localparam int      RESET_TICKS = 9;
	localparam int      PHASE_ITEMS = 285;
	localparam int      LIMIT_TICKS = 400_000;
	localparam int      MAX_PRINTS  = 100;
	localparam word_t   WORD_MAX    = '1;
	localparam word_t   TOP_BIT     = word_t'(1) << (DATA_WIDTH - 1);

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		word_t num;
		word_t den;
	} div_operands_t;

	typedef struct {
		word_t quo;
		logic  dz;
	} div_result_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	word_t dividend = '0;
	word_t divisor_value = '0;
	logic  result_valid;
	logic  result_ready = 1'b0;
	word_t quotient;
	logic  divide_by_zero;

	logic  item_fire = 1'b0;
	int    mismatch_count = 0;

	idle_mode_t    idle_mode = IDLE_NONE;
	div_operands_t divisions_pending[$];
	div_result_t   quotients_due[$];

	egyptian_divider_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.dividend      (dividend),
		.divisor_value (divisor_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.quotient      (quotient),
		.divide_by_zero(divide_by_zero)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_TICKS * CLK_PERIOD);
		$display("FAIL");
		$finish;
	end

	// Double divisor and tally until the divisor passes the dividend, then halve back down,
	// subtracting wherever the divisor still fits.
	function automatic div_result_t divide_egyptian(word_t num, word_t den);
		logic [63:0] tally;
		logic [63:0] dv;
		logic [63:0] rem;
		logic [63:0] quo;
		int          steps;
		div_result_t res;
		res.dz  = (den == '0);
		res.quo = '0;
		if (!res.dz) begin
			tally = 64'd1;
			dv    = 64'(den);
			rem   = 64'(num);
			quo   = '0;
			steps = 0;
			while (dv <= rem && steps <= DATA_WIDTH) begin
				dv    = dv << 1;
				tally = tally << 1;
				steps++;
			end
			while (tally != 0) begin
				if (dv <= rem) begin
					rem = rem - dv;
					quo = quo + tally;
				end
				dv    = dv >> 1;
				tally = tally >> 1;
			end
			res.quo = quo[DATA_WIDTH-1:0];
		end
		return res;
	endfunction

	function automatic bit idle_roll(bit sender_side);
		int pct;
		pct = 0;
		case (idle_mode)
			IDLE_SENDER:   pct = sender_side ? 79 : 0;
			IDLE_RECEIVER: pct = sender_side ? 0 : 79;
			IDLE_BOTH:     pct = 23;
			default:       pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	// Mostly quotients of every size; some zero divisors and divisors above the dividend.
	function automatic div_operands_t random_division();
		div_operands_t op;
		op.num = word_t'($urandom);
		if ($urandom_range(0, 3) == 0)
			op.num = op.num >> $urandom_range(0, DATA_WIDTH - 1);
		case ($urandom_range(0, 9))
			0:       op.den = '0;
			1:       op.den = word_t'($urandom_range(1, 15));
			2, 3:    op.den = (op.num >> $urandom_range(0, DATA_WIDTH - 1))
			                  + word_t'($urandom_range(0, 3));
			4:       op.den = (op.num == WORD_MAX) ? WORD_MAX
			                  : op.num + word_t'($urandom_range(1, 1000));
			default: op.den = word_t'($urandom) >> $urandom_range(0, DATA_WIDTH - 1);
		endcase
		return op;
	endfunction

	task automatic queue_division(word_t num, word_t den);
		div_operands_t op;
		op.num = num;
		op.den = den;
		divisions_pending.push_back(op);
	endtask

	task automatic report_mismatch(string what);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Driver: the payload only moves once the current transaction has been taken.
	always @(negedge clk) begin
		result_ready <= arst_n && !idle_roll(1'b0);
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_fire) begin
			if (divisions_pending.size() != 0 && !idle_roll(1'b1)) begin
				item_valid    <= 1'b1;
				dividend      <= divisions_pending[0].num;
				divisor_value <= divisions_pending[0].den;
				divisions_pending.delete(0);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: predict on input acceptance, check on output acceptance.
	always @(posedge clk) begin
		item_fire <= arst_n && item_valid && item_ready;
		if (arst_n && item_valid && item_ready)
			quotients_due.push_back(divide_egyptian(dividend, divisor_value));
		if (arst_n && result_valid && result_ready) begin
			if (quotients_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result quotient=%0d dz=%0b",
					quotient, divide_by_zero));
			end else begin
				if (quotient !== quotients_due[0].quo)
					report_mismatch($sformatf("quotient got %0d want %0d",
						quotient, quotients_due[0].quo));
				if (divide_by_zero !== quotients_due[0].dz)
					report_mismatch($sformatf("divide_by_zero got %0b want %0b",
						divide_by_zero, quotients_due[0].dz));
				quotients_due.delete(0);
			end
		end
	end

	initial begin
		repeat (RESET_TICKS) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_division('0, '0);
		queue_division(WORD_MAX, '0);
		queue_division('0, word_t'(1));
		queue_division(WORD_MAX, word_t'(1));
		queue_division(WORD_MAX, WORD_MAX);
		queue_division(word_t'(1), WORD_MAX);
		queue_division(WORD_MAX - word_t'(1), WORD_MAX);
		queue_division(WORD_MAX, word_t'(2));
		queue_division(WORD_MAX, TOP_BIT);
		queue_division(TOP_BIT, word_t'(1));
		queue_division(TOP_BIT, word_t'(3));
		queue_division(TOP_BIT, TOP_BIT + word_t'(1));
		queue_division(TOP_BIT - word_t'(1), TOP_BIT);
		queue_division(word_t'(5), word_t'(7));
		queue_division(word_t'(7), word_t'(5));
		queue_division(word_t'(100), word_t'(10));
		queue_division(word_t'(12345), word_t'(1));
		queue_division(word_t'(1), word_t'(1));
		queue_division('0, WORD_MAX);
		queue_division(word_t'(32'h2AAA_AAAA), word_t'(32'h5555_5555));
		queue_division(word_t'(32'h5555_5555), word_t'(32'h2AAA_AAAA));

		for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
			while (divisions_pending.size() != 0) @(negedge clk);
			idle_mode = idle_mode_t'(mode);
			for (int i = 0; i < PHASE_ITEMS; i++)
				divisions_pending.push_back(random_division());
		end

		while (divisions_pending.size() != 0 || item_valid || quotients_due.size() != 0)
			@(negedge clk);
		repeat (2 * DATA_WIDTH + 8) @(negedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	final begin
	end

endmodule
